[rtl/slx_pkg.sv]
// Shared types and constants of the script token lexer.
// Depends on nothing; every other file but slx_queue imports it.
package slx_pkg;

   // Character classes produced by the front decoder.
   typedef enum logic [4:0] {
      CC_NUL,
      CC_OPAREN,
      CC_CPAREN,
      CC_OBRACE,
      CC_CBRACE,
      CC_PLUS,
      CC_MINUS,
      CC_STAR,
      CC_SEMI,
      CC_SLASH,
      CC_BANG,
      CC_AMP,
      CC_PIPE,
      CC_LT,
      CC_GT,
      CC_EQ,
      CC_NEWLINE,
      CC_SPACE,
      CC_DIGIT,
      CC_DOT,
      CC_UPPER,
      CC_LOWER,
      CC_OTHER
   } cclass_type;

   // Token kinds as they appear on the result channel.
   typedef enum logic [4:0] {
      K_OPAREN,
      K_CPAREN,
      K_OBRACE,
      K_CBRACE,
      K_PLUS,
      K_MINUS,
      K_STAR,
      K_SLASH,
      K_LT,
      K_GT,
      K_LE,
      K_GE,
      K_ASSIGN,
      K_EQ,
      K_NE,
      K_AND,
      K_OR,
      K_NUMBER,
      K_VAR,
      K_IF,
      K_ELSE,
      K_WHILE,
      K_PRINT,
      K_TASK,
      K_EXEC,
      K_SEMI,
      K_ERROR,
      K_END
   } kind_type;

   // Keywords packed first byte lowest, zero filled above their length.
   localparam logic [39:0] KW_IF    = 40'h00_0000_6669;
   localparam logic [39:0] KW_ELSE  = 40'h00_6573_6c65;
   localparam logic [39:0] KW_WHILE = 40'h65_6c69_6877;
   localparam logic [39:0] KW_PRINT = 40'h74_6e69_7270;
   localparam logic [39:0] KW_EXEC  = 40'h00_6365_7865;

   localparam logic [7:0] CH_DOT     = 8'h2e;
   localparam logic [7:0] CH_UNDER   = 8'h5f;
   localparam logic [7:0] CH_NEWLINE = 8'h0a;

   // One classified source byte, front to back.
   typedef struct packed {
      cclass_type  cls;
      logic [7:0]  ch;
      logic        last;
   } item_type;

   // One finished result.
   typedef struct packed {
      kind_type    kind;
      logic [15:0] start;
      logic [15:0] len;
      logic [15:0] line;
      logic        unk;
      logic        tdot;
      logic        xdot;
      logic        done;
      logic        last;
   } rsp_type;

endpackage

[rtl/script_token_lexer.sv]
// Top level of the script token lexer: front end, decoupling queue, token engine.
// Depends on slx_pkg, slx_front, slx_queue and slx_back.
//
//   channel  ports                                   direction  carries
//   req      req_valid/req_ready, req_text_byte,     in         one source byte
//            req_end_of_text
//   rsp      rsp_valid/rsp_ready, rsp_token_kind ...  out        one token result
//            rsp_run_last
//
// Rates: one source byte per cycle in unless the engine stalls; results leave at
//   one per cycle while rsp_ready is high, so two results of one byte leave in turn.
// Path: a byte passes three registers on its way to its first result: front register,
//   queue, result buffer.
// Reset: synchronous, clears all token state; the next byte starts a text at
//   offset 0, line 1. No clearing pass.
// Stalls: the two-entry queue lets the front keep taking bytes while the engine
//   waits on the four-entry result buffer; a stalled rsp side backs up to req.
module script_token_lexer #(
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_token_kind,
   output logic [15:0] rsp_start_offset,
   output logic [15:0] rsp_token_length,
   output logic [15:0] rsp_line_number,
   output logic        rsp_unknown_char,
   output logic        rsp_trailing_dot,
   output logic        rsp_extra_dots,
   output logic        rsp_text_done,
   output logic        rsp_run_last
);
   import slx_pkg::*;

   // front to queue
   logic     fq_valid;
   logic     fq_ready;
   item_type fq_item;
   // queue to engine
   logic     qb_valid;
   logic     qb_ready;
   item_type qb_item;
   // engine result
   rsp_type  rsp;

   // classify each byte as it is transferred
   slx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_byte   (req_text_byte),
      .in_last   (req_end_of_text),
      .out_valid (fq_valid),
      .out_ready (fq_ready),
      .out_item  (fq_item)
   );

   // hold classified bytes while the engine waits on the result side
   slx_queue #(
      .item_type (item_type),
      .DEPTH     (2)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_ready (fq_ready),
      .wr_data  (fq_item),
      .rd_valid (qb_valid),
      .rd_ready (qb_ready),
      .rd_data  (qb_item)
   );

   // advance the token state and buffer the results
   slx_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (qb_valid),
      .in_ready  (qb_ready),
      .in_item   (qb_item),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rsp   (rsp)
   );

   // split the buffered result into its ports
   assign rsp_token_kind   = rsp.kind;
   assign rsp_start_offset = rsp.start;
   assign rsp_token_length = rsp.len;
   assign rsp_line_number  = rsp.line;
   assign rsp_unknown_char = rsp.unk;
   assign rsp_trailing_dot = rsp.tdot;
   assign rsp_extra_dots   = rsp.xdot;
   assign rsp_text_done    = rsp.done;
   assign rsp_run_last     = rsp.last;

endmodule

[rtl/slx_front.sv]
// Front end: accepts source bytes and registers their character class.
// Depends on slx_pkg.
module slx_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   output logic              out_valid,
   input  logic              out_ready,
   output slx_pkg::item_type out_item
);
   import slx_pkg::*;

   logic       valid_ff;
   item_type   item_ff;
   cclass_type cls_in;
   logic       load;

   always_comb begin
      unique case (in_byte) inside
         8'h00:                   cls_in = CC_NUL;
         8'h28:                   cls_in = CC_OPAREN;
         8'h29:                   cls_in = CC_CPAREN;
         8'h7b:                   cls_in = CC_OBRACE;
         8'h7d:                   cls_in = CC_CBRACE;
         8'h2b:                   cls_in = CC_PLUS;
         8'h2d:                   cls_in = CC_MINUS;
         8'h2a:                   cls_in = CC_STAR;
         8'h3b:                   cls_in = CC_SEMI;
         8'h2f:                   cls_in = CC_SLASH;
         8'h21:                   cls_in = CC_BANG;
         8'h26:                   cls_in = CC_AMP;
         8'h7c:                   cls_in = CC_PIPE;
         8'h3c:                   cls_in = CC_LT;
         8'h3e:                   cls_in = CC_GT;
         8'h3d:                   cls_in = CC_EQ;
         CH_NEWLINE:              cls_in = CC_NEWLINE;
         8'h20, 8'h09, 8'h0d:     cls_in = CC_SPACE;
         [8'h30:8'h39]:           cls_in = CC_DIGIT;
         CH_DOT:                  cls_in = CC_DOT;
         [8'h41:8'h5a]:           cls_in = CC_UPPER;
         [8'h61:8'h7a], CH_UNDER: cls_in = CC_LOWER;
         default:                 cls_in = CC_OTHER;
      endcase
   end

   assign in_ready  = !valid_ff || out_ready;
   assign load      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (load) begin
         item_ff.cls  <= cls_in;
         item_ff.ch   <= in_byte;
         item_ff.last <= in_last;
      end
   end

endmodule

[rtl/slx_queue.sv]
// Small register queue that decouples the front end from the token engine.
// Depends on nothing beyond its item type parameter.
module slx_queue #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   output logic     wr_ready,
   input  item_type wr_data,
   output logic     rd_valid,
   input  logic     rd_ready,
   output item_type rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff;
   logic [AW-1:0]   rd_ptr_ff;
   logic [CW-1:0]   cnt_ff;
   logic            push;
   logic            pop;

   assign wr_ready = cnt_ff < CW'(DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/slx_back.sv]
// Token engine: holds the unfinished token, emits up to two results per
// byte into a four-entry result buffer. Depends on slx_pkg.
module slx_back #(
   parameter int POSITION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  slx_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output slx_pkg::rsp_type  out_rsp
);
   import slx_pkg::*;

   localparam int PB = POSITION_BITS;

   typedef enum logic [3:0] {
      P_NONE,
      P_SLASH,
      P_BANG,
      P_AMP,
      P_PIPE,
      P_LT,
      P_GT,
      P_ASSIGN,
      P_NUMBER,
      P_IDENT,
      P_COMMENT
   } pclass_type;

   // token state
   pclass_type    pend_ff,   pend_in,   p_pend;
   logic [PB-1:0] pos_ff,    pos_in,    p_pos;
   logic [PB-1:0] start_ff,  start_in,  p_start;
   logic [15:0]   len_ff,    len_in,    p_len;
   logic [15:0]   line_ff,   line_in,   p_line;
   logic [39:0]   prefix_ff, prefix_in, p_prefix;
   logic          upper_ff,  upper_in,  p_upper;
   logic [1:0]    dots_ff,   dots_in,   p_dots;
   logic          ldot_ff,   ldot_in,   p_ldot;

   // result buffer
   rsp_type       buf_ff [4];
   logic [1:0]    rd_ptr_ff;
   logic [1:0]    wr_ptr_ff;
   logic [2:0]    cnt_ff;

   cclass_type    cc;
   logic          has_char, ends, consumed, pair_hit, cont;
   kind_type      pair_kind;
   logic          e_a, e_b, e_c, two, any;
   rsp_type       res_a, res_b, res_c, res_e, r0, r1;
   logic [1:0]    n_res;
   logic          item_pop, rsp_pop;

   function automatic logic [15:0] to16(logic [PB-1:0] p);
      logic [31:0] w;
      w = 32'(p);
      return w[15:0];
   endfunction

   function automatic kind_type ident_kind(logic [39:0] kw, logic [15:0] ln, logic fu);
      kind_type k;
      if (ln == 16'd2 && kw == KW_IF)         k = K_IF;
      else if (ln == 16'd4 && kw == KW_ELSE)  k = K_ELSE;
      else if (ln == 16'd5 && kw == KW_WHILE) k = K_WHILE;
      else if (ln == 16'd5 && kw == KW_PRINT) k = K_PRINT;
      else if (ln == 16'd4 && kw == KW_EXEC)  k = K_EXEC;
      else if (fu)                            k = K_TASK;
      else                                    k = K_VAR;
      return k;
   endfunction

   function automatic logic flush_valid(pclass_type c);
      return c == P_SLASH || c == P_BANG || c == P_LT || c == P_GT ||
             c == P_ASSIGN || c == P_NUMBER || c == P_IDENT;
   endfunction

   function automatic rsp_type flush_res(pclass_type c, logic [PB-1:0] st,
                                         logic [15:0] ln, logic [39:0] kw, logic fu,
                                         logic [1:0] dc, logic ld, logic [15:0] lineno);
      rsp_type r;
      r       = '0;
      r.start = to16(st);
      r.len   = 16'd1;
      r.line  = lineno;
      unique case (c)
         P_SLASH:  r.kind = K_SLASH;
         P_BANG:   begin
            r.kind = K_ERROR;
            r.unk  = 1'b1;
         end
         P_LT:     r.kind = K_LT;
         P_GT:     r.kind = K_GT;
         P_ASSIGN: r.kind = K_ASSIGN;
         P_NUMBER: begin
            r.kind = K_NUMBER;
            r.len  = ln;
            r.tdot = ld;
            r.xdot = dc > 2'd1;
         end
         P_IDENT:  begin
            r.kind = ident_kind(kw, ln, fu);
            r.len  = ln;
         end
         default:  r.kind = K_END;
      endcase
      return r;
   endfunction

   always_comb begin
      cc       = in_item.cls;
      has_char = cc != CC_NUL;
      ends     = !has_char || in_item.last;

      p_pend   = pend_ff;
      p_pos    = pos_ff;
      p_start  = start_ff;
      p_len    = len_ff;
      p_line   = line_ff;
      p_prefix = prefix_ff;
      p_upper  = upper_ff;
      p_dots   = dots_ff;
      p_ldot   = ldot_ff;

      // offer the byte to the unfinished token
      pair_hit  = 1'b0;
      pair_kind = K_NE;
      cont      = 1'b0;
      unique case (pend_ff)
         P_SLASH:   cont = cc == CC_SLASH;
         P_BANG:    begin pair_hit = cc == CC_EQ;   pair_kind = K_NE; end
         P_AMP:     begin pair_hit = cc == CC_AMP;  pair_kind = K_AND; end
         P_PIPE:    begin pair_hit = cc == CC_PIPE; pair_kind = K_OR; end
         P_LT:      begin pair_hit = cc == CC_EQ;   pair_kind = K_LE; end
         P_GT:      begin pair_hit = cc == CC_EQ;   pair_kind = K_GE; end
         P_ASSIGN:  begin pair_hit = cc == CC_EQ;   pair_kind = K_EQ; end
         P_NUMBER:  cont = cc == CC_DIGIT || cc == CC_DOT;
         P_IDENT:   cont = cc == CC_UPPER || cc == CC_LOWER || cc == CC_DIGIT;
         P_COMMENT: cont = cc != CC_NEWLINE;
         default:   cont = 1'b0;
      endcase

      res_a    = flush_res(pend_ff, start_ff, len_ff, prefix_ff, upper_ff, dots_ff,
                           ldot_ff, line_ff);
      e_a      = 1'b0;
      consumed = 1'b0;
      if (has_char && pend_ff != P_NONE) begin
         if (pair_hit) begin
            res_a      = '0;
            res_a.kind = pair_kind;
            res_a.start = to16(start_ff);
            res_a.len  = 16'd2;
            res_a.line = line_ff;
            e_a        = 1'b1;
            consumed   = 1'b1;
            p_pend     = P_NONE;
         end else if (cont) begin
            consumed = 1'b1;
            if (pend_ff == P_SLASH) begin
               p_pend = P_COMMENT;
            end else if (pend_ff == P_NUMBER) begin
               p_len  = (len_ff != 16'hffff) ? len_ff + 16'd1 : len_ff;
               p_dots = (cc == CC_DOT && dots_ff != 2'd2) ? dots_ff + 2'd1 : dots_ff;
               p_ldot = cc == CC_DOT;
            end else if (pend_ff == P_IDENT) begin
               for (int i = 0; i < 5; i++) begin
                  if (len_ff == 16'(i)) begin
                     p_prefix[8*i +: 8] = prefix_ff[8*i +: 8] | in_item.ch;
                  end
               end
               p_len = (len_ff != 16'hffff) ? len_ff + 16'd1 : len_ff;
            end
         end else begin
            e_a    = flush_valid(pend_ff);
            p_pend = P_NONE;
         end
      end

      // start fresh from this byte
      res_b       = '0;
      res_b.start = to16(pos_ff);
      res_b.len   = 16'd1;
      res_b.line  = line_ff;
      res_b.kind  = K_ERROR;
      e_b         = 1'b0;
      if (has_char && !consumed) begin
         unique case (cc)
            CC_OPAREN:  begin e_b = 1'b1; res_b.kind = K_OPAREN; end
            CC_CPAREN:  begin e_b = 1'b1; res_b.kind = K_CPAREN; end
            CC_OBRACE:  begin e_b = 1'b1; res_b.kind = K_OBRACE; end
            CC_CBRACE:  begin e_b = 1'b1; res_b.kind = K_CBRACE; end
            CC_PLUS:    begin e_b = 1'b1; res_b.kind = K_PLUS; end
            CC_MINUS:   begin e_b = 1'b1; res_b.kind = K_MINUS; end
            CC_STAR:    begin e_b = 1'b1; res_b.kind = K_STAR; end
            CC_SEMI:    begin e_b = 1'b1; res_b.kind = K_SEMI; end
            CC_SLASH:   p_pend = P_SLASH;
            CC_BANG:    p_pend = P_BANG;
            CC_AMP:     p_pend = P_AMP;
            CC_PIPE:    p_pend = P_PIPE;
            CC_LT:      p_pend = P_LT;
            CC_GT:      p_pend = P_GT;
            CC_EQ:      p_pend = P_ASSIGN;
            CC_NEWLINE: p_line = (line_ff != 16'hffff) ? line_ff + 16'd1 : line_ff;
            CC_SPACE:   e_b = 1'b0;
            CC_DIGIT, CC_DOT: begin
               p_pend = P_NUMBER;
               p_dots = {1'b0, cc == CC_DOT};
               p_ldot = cc == CC_DOT;
            end
            CC_UPPER, CC_LOWER: begin
               p_pend   = P_IDENT;
               p_prefix = {32'd0, in_item.ch};
               p_upper  = cc == CC_UPPER;
            end
            default:    begin e_b = 1'b1; res_b.unk = 1'b1; end
         endcase
         if (p_pend != pend_ff || (pend_ff == P_NONE) || consumed == 1'b0) begin
            if (p_pend != P_NONE) begin
               p_start = pos_ff;
               p_len   = 16'd1;
            end
         end
      end
      if (has_char) begin
         p_pos = pos_ff + 1'b1;
      end

      // end of text: flush what is left, or report the bare end
      e_c   = ends && flush_valid(p_pend);
      res_c = flush_res(p_pend, p_start, p_len, p_prefix, p_upper, p_dots, p_ldot, p_line);
      res_e       = '0;
      res_e.kind  = K_END;
      res_e.start = to16(p_pos);
      res_e.line  = p_line;

      two = e_a && (e_b || e_c);
      any = e_a || e_b || e_c || ends;
      r0  = e_a ? res_a : (e_b ? res_b : (e_c ? res_c : res_e));
      r1  = e_b ? res_b : res_c;
      if (two) begin
         r1.last = 1'b1;
         r1.done = ends;
      end else begin
         r0.last = 1'b1;
         r0.done = ends;
      end
      n_res = two ? 2'd2 : (any ? 2'd1 : 2'd0);

      if (ends) begin
         pend_in   = P_NONE;
         pos_in    = '0;
         start_in  = '0;
         len_in    = '0;
         line_in   = 16'd1;
         prefix_in = '0;
         upper_in  = 1'b0;
         dots_in   = '0;
         ldot_in   = 1'b0;
      end else begin
         pend_in   = p_pend;
         pos_in    = p_pos;
         start_in  = p_start;
         len_in    = p_len;
         line_in   = p_line;
         prefix_in = p_prefix;
         upper_in  = p_upper;
         dots_in   = p_dots;
         ldot_in   = p_ldot;
      end
   end

   // take a byte only when the buffer has room for two results
   assign in_ready  = cnt_ff <= 3'd2;
   assign item_pop  = in_valid && in_ready;
   assign out_valid = cnt_ff != 3'd0;
   assign out_rsp   = buf_ff[rd_ptr_ff];
   assign rsp_pop   = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= P_NONE;
         pos_ff    <= '0;
         start_ff  <= '0;
         len_ff    <= '0;
         line_ff   <= 16'd1;
         prefix_ff <= '0;
         upper_ff  <= 1'b0;
         dots_ff   <= '0;
         ldot_ff   <= 1'b0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (item_pop) begin
            pend_ff   <= pend_in;
            pos_ff    <= pos_in;
            start_ff  <= start_in;
            len_ff    <= len_in;
            line_ff   <= line_in;
            prefix_ff <= prefix_in;
            upper_ff  <= upper_in;
            dots_ff   <= dots_in;
            ldot_ff   <= ldot_in;
            wr_ptr_ff <= wr_ptr_ff + n_res;
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         cnt_ff <= cnt_ff + (item_pop ? {1'b0, n_res} : 3'd0) - {2'd0, rsp_pop};
      end
      if (item_pop && n_res != 2'd0) begin
         buf_ff[wr_ptr_ff] <= r0;
      end
      if (item_pop && two) begin
         buf_ff[wr_ptr_ff + 2'd1] <= r1;
      end
   end

   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4)
      else $error("result buffer overfilled");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (item_pop && ends) |=> (pend_ff == P_NONE && pos_ff == '0 && line_ff == 16'd1))
      else $error("token state not cleared after end of text");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != 16'd0)
      else $error("line counter reached zero");

   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (item_pop && ends) |=> cnt_ff != 3'd0)
      else $error("end of text produced no result");

endmodule

[tb/sv/testbench.sv]
// Self-checking bench for script_token_lexer: a byte-level lexer written here
// predicts every token, and a monitor matches the result stream against it.
// Depends on slx_pkg and the script_token_lexer RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import slx_pkg::*;

   // Unfinished token held between bytes.
   typedef enum logic [3:0] {
      PD_NONE, PD_SLASH, PD_BANG, PD_AMP, PD_PIPE, PD_LT, PD_GT,
      PD_ASSIGN, PD_NUMBER, PD_IDENT, PD_COMMENT
   } pend_type;

   // How a text is closed: flag on its last byte, or a zero byte after it, with or without the flag.
   typedef enum {ENDS_ON_FLAG, ENDS_ON_NUL, ENDS_ON_NUL_FLAG} text_end_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] start;
      logic [15:0] len;
      logic [15:0] line;
      logic        unk;
      logic        tdot;
      logic        xdot;
      logic        done;
      logic        last;
   } token_type;

   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_CR   = 8'h0d;
   localparam logic [15:0] SAT16  = 16'hffff;
   localparam int RANDOM_BYTES    = 1000;

   string keywords[5] = '{"if", "else", "while", "print", "exec"};
   string operators[21] = '{"(", ")", "{", "}", "+", "-", "*", ";", "/", "<", ">",
                            "=", "<=", ">=", "==", "!=", "&&", "||", "!", "&", "|"};

   // ---------------------------------------------------------------------
   // Block ports; every input starts at a known value.
   // ---------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_text_byte = 8'h00;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_token_kind;
   logic [15:0] rsp_start_offset;
   logic [15:0] rsp_token_length;
   logic [15:0] rsp_line_number;
   logic        rsp_unknown_char;
   logic        rsp_trailing_dot;
   logic        rsp_extra_dots;
   logic        rsp_text_done;
   logic        rsp_run_last;

   int unsigned sender_idle = 29;
   int unsigned receiver_idle = 79;
   int          mismatch_count = 0;
   int          bytes_sent = 0;

   // Tokens produced by the current byte, and tokens awaited from the block.
   token_type   step_tokens[$];
   token_type   tokens_in_flight[$];

   // Lexer state mirrored from the block.
   pend_type    lx_pend;
   logic [15:0] lx_pos;
   logic [15:0] lx_line;
   logic [15:0] lx_start;
   logic [15:0] lx_len;
   logic [39:0] lx_prefix;
   logic        lx_upper;
   logic [1:0]  lx_dots;
   logic        lx_dot_last;

   script_token_lexer #(.POSITION_BITS(16)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_start_offset (rsp_start_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_line_number  (rsp_line_number),
      .rsp_unknown_char (rsp_unknown_char),
      .rsp_trailing_dot (rsp_trailing_dot),
      .rsp_extra_dots   (rsp_extra_dots),
      .rsp_text_done    (rsp_text_done),
      .rsp_run_last     (rsp_run_last)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Token predictor
   // ---------------------------------------------------------------------
   function automatic bit digit_char(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_upper(logic [7:0] c);
      return c >= "A" && c <= "Z";
   endfunction

   function automatic bit letter_char(logic [7:0] c);
      return is_upper(c) || (c >= "a" && c <= "z");
   endfunction

   function void clear_lexer();
      lx_pend     = PD_NONE;
      lx_pos      = '0;
      lx_line     = 16'd1;
      lx_start    = '0;
      lx_len      = '0;
      lx_prefix   = '0;
      lx_upper    = 1'b0;
      lx_dots     = '0;
      lx_dot_last = 1'b0;
   endfunction

   // Queue one token of this byte, tagged with the current line; at most two per byte.
   function void add_token(kind_type k, logic [15:0] st, logic [15:0] ln,
                           logic unk, logic td, logic xd);
      token_type t;
      if (step_tokens.size() >= 2)
         return;
      t.kind  = k;
      t.start = st;
      t.len   = ln;
      t.line  = lx_line;
      t.unk   = unk;
      t.tdot  = td;
      t.xdot  = xd;
      t.done  = 1'b0;
      t.last  = 1'b0;
      step_tokens.push_back(t);
   endfunction

   function void open_token(pend_type p);
      lx_pend  = p;
      lx_start = lx_pos;
      lx_len   = 16'd1;
   endfunction

   function void grow_token();
      if (lx_len != SAT16)
         lx_len++;
   endfunction

   // Keyword match on the first five bytes, then task or variable by first letter.
   function kind_type word_kind();
      if (lx_len == 16'd2 && lx_prefix == KW_IF)    return K_IF;
      if (lx_len == 16'd4 && lx_prefix == KW_ELSE)  return K_ELSE;
      if (lx_len == 16'd5 && lx_prefix == KW_WHILE) return K_WHILE;
      if (lx_len == 16'd5 && lx_prefix == KW_PRINT) return K_PRINT;
      if (lx_len == 16'd4 && lx_prefix == KW_EXEC)  return K_EXEC;
      return lx_upper ? K_TASK : K_VAR;
   endfunction

   // Emit whatever is pending; lone '&' and '|' and comments leave nothing.
   function void flush_token();
      case (lx_pend)
         PD_SLASH:  add_token(K_SLASH, lx_start, 16'd1, 1'b0, 1'b0, 1'b0);
         PD_BANG:   add_token(K_ERROR, lx_start, 16'd1, 1'b1, 1'b0, 1'b0);
         PD_LT:     add_token(K_LT, lx_start, 16'd1, 1'b0, 1'b0, 1'b0);
         PD_GT:     add_token(K_GT, lx_start, 16'd1, 1'b0, 1'b0, 1'b0);
         PD_ASSIGN: add_token(K_ASSIGN, lx_start, 16'd1, 1'b0, 1'b0, 1'b0);
         PD_NUMBER: add_token(K_NUMBER, lx_start, lx_len, 1'b0, lx_dot_last, lx_dots > 2'd1);
         PD_IDENT:  add_token(word_kind(), lx_start, lx_len, 1'b0, 1'b0, 1'b0);
         default: ;
      endcase
      lx_pend = PD_NONE;
   endfunction

   // Offer a byte to the pending token; 1 when the token took it.
   function bit absorb(logic [7:0] c);
      kind_type pair;
      bit       paired;
      paired = 1'b0;
      pair   = K_ERROR;
      case (lx_pend)
         PD_NONE: return 1'b0;
         PD_SLASH: if (c == "/") begin
            lx_pend = PD_COMMENT;
            return 1'b1;
         end
         PD_BANG: if (c == "=") begin
            pair = K_NE;
            paired = 1'b1;
         end
         PD_AMP: if (c == "&") begin
            pair = K_AND;
            paired = 1'b1;
         end
         PD_PIPE: if (c == "|") begin
            pair = K_OR;
            paired = 1'b1;
         end
         PD_LT: if (c == "=") begin
            pair = K_LE;
            paired = 1'b1;
         end
         PD_GT: if (c == "=") begin
            pair = K_GE;
            paired = 1'b1;
         end
         PD_ASSIGN: if (c == "=") begin
            pair = K_EQ;
            paired = 1'b1;
         end
         PD_NUMBER: if (digit_char(c) || c == CH_DOT) begin
            grow_token();
            if (c == CH_DOT && lx_dots < 2'd2)
               lx_dots++;
            lx_dot_last = (c == CH_DOT);
            return 1'b1;
         end
         PD_IDENT: if (letter_char(c) || digit_char(c) || c == CH_UNDER) begin
            if (lx_len < 16'd5)
               lx_prefix = lx_prefix | (40'(c) << (8 * lx_len));
            grow_token();
            return 1'b1;
         end
         PD_COMMENT: begin
            if (c != CH_NEWLINE)
               return 1'b1;
            lx_pend = PD_NONE;
            return 1'b0;
         end
         default: begin
            lx_pend = PD_NONE;
            return 1'b0;
         end
      endcase
      if (paired) begin
         add_token(pair, lx_start, 16'd2, 1'b0, 1'b0, 1'b0);
         lx_pend = PD_NONE;
         return 1'b1;
      end
      flush_token();
      return 1'b0;
   endfunction

   // Lex a byte that no pending token took.
   function void fresh_token(logic [7:0] c);
      case (c)
         "(": add_token(K_OPAREN, lx_pos, 16'd1, 1'b0, 1'b0, 1'b0);
         ")": add_token(K_CPAREN, lx_pos, 16'd1, 1'b0, 1'b0, 1'b0);
         "{": add_token(K_OBRACE, lx_pos, 16'd1, 1'b0, 1'b0, 1'b0);
         "}": add_token(K_CBRACE, lx_pos, 16'd1, 1'b0, 1'b0, 1'b0);
         "+": add_token(K_PLUS, lx_pos, 16'd1, 1'b0, 1'b0, 1'b0);
         "-": add_token(K_MINUS, lx_pos, 16'd1, 1'b0, 1'b0, 1'b0);
         "*": add_token(K_STAR, lx_pos, 16'd1, 1'b0, 1'b0, 1'b0);
         ";": add_token(K_SEMI, lx_pos, 16'd1, 1'b0, 1'b0, 1'b0);
         "/": open_token(PD_SLASH);
         "!": open_token(PD_BANG);
         "&": open_token(PD_AMP);
         "|": open_token(PD_PIPE);
         "<": open_token(PD_LT);
         ">": open_token(PD_GT);
         "=": open_token(PD_ASSIGN);
         CH_NEWLINE: if (lx_line != SAT16) lx_line++;
         " ", CH_TAB, CH_CR: ;
         default: begin
            if (digit_char(c) || c == CH_DOT) begin
               open_token(PD_NUMBER);
               lx_dots     = (c == CH_DOT) ? 2'd1 : 2'd0;
               lx_dot_last = (c == CH_DOT);
            end else if (letter_char(c) || c == CH_UNDER) begin
               open_token(PD_IDENT);
               lx_prefix = 40'(c);
               lx_upper  = is_upper(c);
            end else begin
               add_token(K_ERROR, lx_pos, 16'd1, 1'b1, 1'b0, 1'b0);
            end
         end
      endcase
   endfunction

   // Predict the tokens of one accepted byte and queue them in order.
   function void lex_step(logic [7:0] c, logic eot);
      step_tokens.delete();
      if (c != CH_NUL) begin
         if (!absorb(c))
            fresh_token(c);
         lx_pos++;
      end
      if (c == CH_NUL || eot) begin
         flush_token();
         if (step_tokens.size() == 0)
            add_token(K_END, lx_pos, 16'd0, 1'b0, 1'b0, 1'b0);
         step_tokens[step_tokens.size() - 1].done = 1'b1;
         clear_lexer();
      end
      if (step_tokens.size() != 0)
         step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i])
         tokens_in_flight.push_back(step_tokens[i]);
   endfunction

   // ---------------------------------------------------------------------
   // Result side: random backpressure, and the token monitor
   // ---------------------------------------------------------------------
   always @(negedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= receiver_idle);

   function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Match every result transfer against the oldest predicted token.
   always @(posedge clock) begin : token_monitor
      token_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (tokens_in_flight.size() == 0) begin
            $display("%0t: unexpected result, kind expected none, got %0d",
                     $time, rsp_token_kind);
            mismatch_count++;
         end else begin
            want = tokens_in_flight.pop_front();
            check_field("token_kind", 16'(want.kind), 16'(rsp_token_kind));
            check_field("start_offset", want.start, rsp_start_offset);
            check_field("token_length", want.len, rsp_token_length);
            check_field("line_number", want.line, rsp_line_number);
            check_field("unknown_char", 16'(want.unk), 16'(rsp_unknown_char));
            check_field("trailing_dot", 16'(want.tdot), 16'(rsp_trailing_dot));
            check_field("extra_dots", 16'(want.xdot), 16'(rsp_extra_dots));
            check_field("text_done", 16'(want.done), 16'(rsp_text_done));
            check_field("run_last", 16'(want.last), 16'(rsp_run_last));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Byte sender and text builders
   // ---------------------------------------------------------------------

   // Enter and leave at a falling edge; valid stays high into the next call.
   task automatic send_byte(logic [7:0] c, logic eot);
      // drop valid for random idle cycles
      while ($urandom_range(0, 99) < sender_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_text_byte   = c;
      req_end_of_text = eot;
      // hold until the transfer happens
      do @(posedge clock); while (!req_ready);
      lex_step(c, eot);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(ref logic [7:0] text[$], input text_end_type ending);
      for (int i = 0; i < text.size(); i++)
         send_byte(text[i], ending == ENDS_ON_FLAG && i == text.size() - 1);
      if (ending != ENDS_ON_FLAG || text.size() == 0)
         send_byte(CH_NUL, ending == ENDS_ON_NUL_FLAG);
   endtask

   task automatic push_string(ref logic [7:0] text[$], input string s);
      for (int i = 0; i < s.len(); i++)
         text.push_back(s[i]);
   endtask

   task automatic send_string(string s, text_end_type ending);
      logic [7:0] text[$];
      push_string(text, s);
      send_text(text, ending);
   endtask

   function automatic logic [7:0] pick_word_char(bit lead);
      int unsigned r;
      r = $urandom_range(0, lead ? 52 : 62);
      if (r < 26)
         return "A" + 8'(r);
      else if (r < 52)
         return "a" + 8'(r - 26);
      else if (r == 52)
         return CH_UNDER;
      return "0" + 8'(r - 53);
   endfunction

   // Append one mostly well-formed piece of source text.
   task automatic add_fragment(ref logic [7:0] text[$]);
      int unsigned n;
      case ($urandom_range(0, 9))
         0: push_string(text, keywords[$urandom_range(0, 4)]);
         1, 9: begin
            n = $urandom_range(0, 6);
            text.push_back(pick_word_char(1'b1));
            repeat (n) text.push_back(pick_word_char(1'b0));
         end
         2: begin
            n = $urandom_range(1, 6);
            repeat (n) text.push_back($urandom_range(0, 4) == 0 ? CH_DOT
                                      : "0" + 8'($urandom_range(0, 9)));
         end
         3, 4: push_string(text, operators[$urandom_range(0, 20)]);
         5: begin
            case ($urandom_range(0, 2))
               0: text.push_back(" ");
               1: text.push_back(CH_TAB);
               default: text.push_back(CH_CR);
            endcase
         end
         6: text.push_back(CH_NEWLINE);
         7: begin
            push_string(text, "//");
            n = $urandom_range(0, 5);
            repeat (n) text.push_back(8'($urandom_range(1, 255)));
            text.push_back(CH_NEWLINE);
         end
         default: text.push_back(8'($urandom_range(1, 255)));
      endcase
      // separate words now and then, let them run together otherwise
      if ($urandom_range(0, 2) == 0)
         text.push_back(" ");
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Single operators, pairs, lone operators ahead of other bytes.
   task automatic test_operators();
      send_string("(){}+-*;<=>=!===&&||< > =/!&|x", ENDS_ON_NUL);
   endtask

   // Lookahead characters as the very last byte of a text.
   task automatic test_end_lookahead();
      string s;
      s = "<>=/!&|";
      for (int i = 0; i < s.len(); i++)
         send_string(s.substr(i, i), ENDS_ON_FLAG);
      send_string("a//c", ENDS_ON_FLAG);
   endtask

   // Number dot flags, every keyword, task names and near-keywords.
   task automatic test_numbers_and_words();
      send_string("1.2. 3..4 if else while print exec Go _9 ifx", ENDS_ON_FLAG);
   endtask

   // Comments up to the newline, whitespace, line count.
   task automatic test_comments_and_lines();
      send_string("/ x//c(\n\t\015;", ENDS_ON_NUL_FLAG);
   endtask

   // Byte extremes, empty text, zero byte without the flag.
   task automatic test_byte_extremes();
      send_byte(CH_NUL, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b1);
      send_byte(CH_NUL, 1'b1);
   endtask

   // Random texts, with raw noise bytes mixed in between them.
   task automatic test_random_texts(int count);
      logic [7:0]  text[$];
      int          stop_at;
      int unsigned n;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 10);
            repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         end else begin
            text.delete();
            n = $urandom_range(0, 12);
            repeat (n) add_fragment(text);
            send_text(text, text_end_type'($urandom_range(0, 2)));
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      clear_lexer();
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // sender idles lightly, receiver heavily
      test_operators();
      test_end_lookahead();
      test_numbers_and_words();
      test_comments_and_lines();
      test_byte_extremes();
      test_random_texts(RANDOM_BYTES / 3);

      // the other way round
      sender_idle   = 79;
      receiver_idle = 29;
      test_random_texts(RANDOM_BYTES / 3);

      // full rate on both sides
      sender_idle   = 0;
      receiver_idle = 0;
      test_random_texts(RANDOM_BYTES / 3);

      req_valid = 1'b0;
      // drain, then give the pipeline time to show any stray result
      while (tokens_in_flight.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("script_token_lexer regression: pass");
      else
         $display("script_token_lexer regression: fail");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("script_token_lexer regression: fail");
      $finish;
   end

endmodule
